// ----- hdl/rnad_pkg.sv -----
package rnad_pkg;

    // default geometry limits and queue size
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 4096;
    localparam int DEF_QUEUE_DEPTH = 4;

    // pixel and arithmetic widths
    localparam int PIX_W       = 24;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 11;   // 8 taps * 255
    localparam int CNT_W       = 4;    // 0..8 taps
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 14;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // window layout: index = column * 3 + row, column 0 is the oldest
    localparam int WIN_TAPS   = 9;
    localparam int WIN_SIDE   = 3;
    localparam int WIN_CENTRE = 4;

    // register file
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 4;
    localparam int REG_IDX_W  = 2;
    localparam int BG_REG_W   = 24;
    localparam int FW_REG_W   = 11;
    localparam int FH_REG_W   = 13;

    localparam logic [REG_IDX_W-1:0] REG_BACKGROUND = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT     = 2'd2;

    // request type of an input transfer
    localparam logic REQ_PIXEL = 1'b0;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        logic left_ok;
        logic right_ok;
        logic up_ok;
        logic down_ok;
        logic eof;
    } t_edges;

    typedef struct packed {
        t_pixel [WIN_TAPS-1:0] win;
        t_edges                edges;
    } t_job;

    typedef struct packed {
        logic [FW_REG_W-1:0] width;
        logic [FH_REG_W-1:0] height;
        logic                restart;
    } t_geom;

    // ceil(2^RECIP_SHIFT / cnt); exact floor division for sums below 2^SUM_W
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 15'd16384;
            4'd2:    m = 15'd8192;
            4'd3:    m = 15'd5462;
            4'd4:    m = 15'd4096;
            4'd5:    m = 15'd3277;
            4'd6:    m = 15'd2731;
            4'd7:    m = 15'd2341;
            4'd8:    m = 15'd2048;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ----- hdl/rnad_ifs.sv -----
interface rnad_pix_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, req_type, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, req_type, red_in, green_in, blue_in, output ready);
endinterface

interface rnad_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       end_of_frame;

    modport source (output valid, red_out, green_out, blue_out, end_of_frame, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, end_of_frame, output ready);
endinterface

// ----- hdl/rnad_ram.sv -----
module rnad_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/rnad_queue.sv -----
module rnad_queue #(
    parameter int DEPTH = rnad_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  rnad_pkg::t_job             i_data,
    input  logic                       i_pop,
    output rnad_pkg::t_job             o_head,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int QW = $clog2(DEPTH+1);

    rnad_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [QW-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

// ----- hdl/rnad_front.sv -----
module rnad_front #(
    parameter int MAX_WIDTH   = rnad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = rnad_pkg::DEF_MAX_HEIGHT,
    parameter int QUEUE_DEPTH = rnad_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rnad_pix_in_if.sink                      i_pix,
    input  rnad_pkg::t_geom                  i_geom,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_q_count,
    output logic                             o_push,
    output rnad_pkg::t_job                   o_job
);

    localparam int CW  = $clog2(MAX_WIDTH);       // column index
    localparam int WW  = $clog2(MAX_WIDTH+1);     // width value
    localparam int YW  = $clog2(MAX_HEIGHT);      // output row index
    localparam int HW  = $clog2(MAX_HEIGHT+1);    // height value
    localparam int RW  = $clog2(MAX_HEIGHT+2);    // input row, runs to height + 1
    localparam int QW  = $clog2(QUEUE_DEPTH+1);
    localparam int FWW = (WW > rnad_pkg::FW_REG_W) ? WW : rnad_pkg::FW_REG_W;
    localparam int FHW = (HW > rnad_pkg::FH_REG_W) ? HW : rnad_pkg::FH_REG_W;

    logic [FWW-1:0] fw_ext;
    logic [FHW-1:0] fh_ext;
    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;

    // clamp geometry into 1..MAX
    always_comb begin
        fw_ext = FWW'(i_geom.width);
        fh_ext = FHW'(i_geom.height);
        if (fw_ext == '0) begin
            w_eff = WW'(1);
        end else if (fw_ext > FWW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(fw_ext);
        end
        if (fh_ext == '0) begin
            h_eff = HW'(1);
        end else if (fh_ext > FHW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(fh_ext);
        end
    end

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_ox, n_ox;
    logic [YW-1:0] r_oy, n_oy;

    logic                 r_s1_valid;
    logic                 r_s1_push;
    logic [CW-1:0]        r_s1_col;
    rnad_pkg::t_pixel     r_s1_new;
    rnad_pkg::t_edges     r_s1_edges;

    logic                 r_byp, n_byp;
    rnad_pkg::t_pixel     r_byp_far;
    rnad_pkg::t_pixel     r_byp_near;

    rnad_pkg::t_pixel [rnad_pkg::WIN_TAPS-1:0] r_win, n_win;

    logic             in_frame;
    logic             take;
    logic             go;
    logic             emit;
    logic [QW:0]      credit;
    logic [WW-1:0]    col_inc;
    logic [WW-1:0]    ox_inc;
    logic [HW-1:0]    oy_inc;
    rnad_pkg::t_pixel new_pix;
    rnad_pkg::t_edges edges;
    rnad_pkg::t_pixel near_rd, far_rd;
    rnad_pkg::t_pixel near_v, far_v;

    // room for this transfer and the one already in stage 1
    assign credit      = (QW+1)'(i_q_count) + (QW+1)'(r_s1_push);
    assign i_pix.ready = credit < (QW+1)'(QUEUE_DEPTH);

    assign in_frame = r_row < RW'(h_eff);
    assign take     = i_pix.valid && i_pix.ready;
    // drain ticks inside the frame are dropped
    assign go       = take && (!in_frame || (i_pix.req_type == rnad_pkg::REQ_PIXEL));
    assign new_pix  = in_frame ? {i_pix.red_in, i_pix.green_in, i_pix.blue_in} : '0;
    // first result comes once row 1 column 1 has arrived
    assign emit     = !((r_row == '0) || ((r_row == RW'(1)) && (r_col == '0)));

    assign col_inc = WW'(r_col) + WW'(1);
    assign ox_inc  = WW'(r_ox) + WW'(1);
    assign oy_inc  = HW'(r_oy) + HW'(1);

    always_comb begin
        edges.left_ok  = r_ox != '0;
        edges.right_ok = ox_inc < w_eff;
        edges.up_ok    = r_oy != '0;
        edges.down_ok  = oy_inc < h_eff;
        edges.eof      = (ox_inc == w_eff) && (oy_inc == h_eff);
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_ox  = r_ox;
        n_oy  = r_oy;
        if (i_geom.restart) begin
            n_col = '0;
            n_row = '0;
            n_ox  = '0;
            n_oy  = '0;
        end else if (go) begin
            if (col_inc == w_eff) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = CW'(col_inc);
            end
            if (emit) begin
                if (edges.eof) begin
                    n_col = '0;
                    n_row = '0;
                    n_ox  = '0;
                    n_oy  = '0;
                end else if (ox_inc == w_eff) begin
                    n_ox = '0;
                    n_oy = YW'(oy_inc);
                end else begin
                    n_ox = CW'(ox_inc);
                end
            end
        end
    end

    rnad_ram #(.WIDTH(rnad_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_near (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_new),
        .i_re    (go),
        .i_raddr (r_col),
        .o_rdata (near_rd)
    );

    rnad_ram #(.WIDTH(rnad_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_far (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (near_v),
        .i_re    (go),
        .i_raddr (r_col),
        .o_rdata (far_rd)
    );

    // one-pixel rows: the read collides with the write of the previous pixel
    assign far_v  = r_byp ? r_byp_far  : far_rd;
    assign near_v = r_byp ? r_byp_near : near_rd;
    assign n_byp  = go && r_s1_valid && (r_col == r_s1_col);

    always_comb begin
        n_win = r_win;
        if (r_s1_valid) begin
            for (int i = 0; i < rnad_pkg::WIN_TAPS - rnad_pkg::WIN_SIDE; i++) begin
                n_win[i] = r_win[i + rnad_pkg::WIN_SIDE];
            end
            n_win[rnad_pkg::WIN_TAPS-3] = far_v;
            n_win[rnad_pkg::WIN_TAPS-2] = near_v;
            n_win[rnad_pkg::WIN_TAPS-1] = r_s1_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_ox       <= '0;
            r_oy       <= '0;
            r_s1_valid <= 1'b0;
            r_s1_push  <= 1'b0;
            r_byp      <= 1'b0;
            r_win      <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_ox       <= n_ox;
            r_oy       <= n_oy;
            r_s1_valid <= go;
            r_s1_push  <= go && emit;
            r_byp      <= n_byp;
            r_win      <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1_col   <= r_col;
            r_s1_new   <= new_pix;
            r_s1_edges <= edges;
        end
        if (n_byp) begin
            r_byp_far  <= near_v;
            r_byp_near <= r_s1_new;
        end
    end

    assign o_push      = r_s1_push;
    assign o_job.win   = n_win;
    assign o_job.edges = r_s1_edges;

endmodule

// ----- hdl/rnad_back.sv -----
module rnad_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  rnad_pkg::t_job                     i_head,
    input  logic [rnad_pkg::BG_REG_W-1:0]      i_bg,
    output logic                               o_pop,
    rnad_pix_out_if.source                     o_pix
);

    localparam int SW = rnad_pkg::SUM_W;
    localparam int KW = rnad_pkg::CNT_W;
    localparam int PW = rnad_pkg::PROD_W;
    localparam int CH = rnad_pkg::CHAN_W;
    localparam int SH = rnad_pkg::RECIP_SHIFT;

    logic adv;

    logic             r_b1_valid;
    logic [SW-1:0]    r_b1_sum_r, r_b1_sum_g, r_b1_sum_b;
    logic [KW-1:0]    r_b1_cnt;
    rnad_pkg::t_pixel r_b1_centre;
    logic             r_b1_eof;

    logic             r_b2_valid;
    logic [PW-1:0]    r_b2_prod_r, r_b2_prod_g, r_b2_prod_b;
    logic             r_b2_has;
    rnad_pkg::t_pixel r_b2_centre;
    logic             r_b2_eof;

    logic             r_out_valid;
    logic [CH-1:0]    r_red, r_green, r_blue;
    logic             r_eof;

    logic [SW-1:0]    n_sum_r, n_sum_g, n_sum_b;
    logic [KW-1:0]    n_cnt;
    logic [PW-1:0]    mult;
    rnad_pkg::t_pixel tap;
    logic             tap_on;

    assign adv   = !r_out_valid || o_pix.ready;
    assign o_pop = adv && i_q_valid;
    assign mult  = PW'(rnad_pkg::recip(r_b1_cnt));

    // gather the in-frame, non-background neighbours
    always_comb begin
        n_sum_r = '0;
        n_sum_g = '0;
        n_sum_b = '0;
        n_cnt   = '0;
        tap     = '0;
        tap_on  = 1'b0;
        for (int c = 0; c < rnad_pkg::WIN_SIDE; c++) begin
            for (int r = 0; r < rnad_pkg::WIN_SIDE; r++) begin
                tap    = i_head.win[c * rnad_pkg::WIN_SIDE + r];
                tap_on = (c * rnad_pkg::WIN_SIDE + r != rnad_pkg::WIN_CENTRE)
                      && ((c != 0) || i_head.edges.left_ok)
                      && ((c != 2) || i_head.edges.right_ok)
                      && ((r != 0) || i_head.edges.up_ok)
                      && ((r != 2) || i_head.edges.down_ok)
                      && (tap != i_bg);
                if (tap_on) begin
                    n_sum_r = n_sum_r + SW'(tap[23:16]);
                    n_sum_g = n_sum_g + SW'(tap[15:8]);
                    n_sum_b = n_sum_b + SW'(tap[7:0]);
                    n_cnt   = n_cnt + KW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_b1_valid  <= i_q_valid;
            r_b2_valid  <= r_b1_valid;
            r_out_valid <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1_sum_r  <= n_sum_r;
            r_b1_sum_g  <= n_sum_g;
            r_b1_sum_b  <= n_sum_b;
            r_b1_cnt    <= n_cnt;
            r_b1_centre <= i_head.win[rnad_pkg::WIN_CENTRE];
            r_b1_eof    <= i_head.edges.eof;

            // mean by reciprocal multiply
            r_b2_prod_r <= PW'(r_b1_sum_r) * mult;
            r_b2_prod_g <= PW'(r_b1_sum_g) * mult;
            r_b2_prod_b <= PW'(r_b1_sum_b) * mult;
            r_b2_has    <= r_b1_cnt != '0;
            r_b2_centre <= r_b1_centre;
            r_b2_eof    <= r_b1_eof;

            r_red   <= r_b2_has ? r_b2_prod_r[SH +: CH] : r_b2_centre[23:16];
            r_green <= r_b2_has ? r_b2_prod_g[SH +: CH] : r_b2_centre[15:8];
            r_blue  <= r_b2_has ? r_b2_prod_b[SH +: CH] : r_b2_centre[7:0];
            r_eof   <= r_b2_eof;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.red_out      = r_red;
    assign o_pix.green_out    = r_green;
    assign o_pix.blue_out     = r_blue;
    assign o_pix.end_of_frame = r_eof;

endmodule

// ----- hdl/rgb_neighbor_average_dilate.sv -----
// RGB 3x3 neighbor-average dilation over a raster pixel stream.
// Input channel i_pix: one transfer per pixel in raster order (req_type pixel),
// then frame_width + 1 drain transfers (req_type drain) to flush the frame.
// Output channel o_pix: one filtered pixel per transfer, raster order, with
// end_of_frame on the last pixel; after it the next frame starts.
// Registers over APB: 0x0 background color, 0x4 frame width, 0x8 frame
// height. Writing width or height restarts the frame; write only while idle.
// Path: the result for pixel j leaves on input transfer j + width + 1 and
// passes stage 1, the window queue and the b1, b2 and output registers to o_pix.
// Throughput: one transfer per cycle while i_pix.ready is high. Line stores
// are read when a transfer is taken and written in the next cycle (bypass on
// same column back to back); averaging takes a window per cycle when not held.
// Reset: counters go to zero, registers to their defaults; the line stores
// are not cleared and no clearing pass runs, so the block is ready at once.
// Stall: a 4-entry queue sits between the front and the averaging pipeline.
// When o_pix is held off the queue fills and i_pix.ready drops.
module rgb_neighbor_average_dilate #(
    parameter int MAX_WIDTH   = rnad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = rnad_pkg::DEF_MAX_HEIGHT,
    parameter int QUEUE_DEPTH = rnad_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rnad_pix_in_if.sink                       i_pix,
    rnad_pix_out_if.source                    o_pix,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rnad_pkg::PADDR_W-1:0]      paddr,
    input  logic [rnad_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rnad_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int QW = $clog2(QUEUE_DEPTH+1);

    // register file
    logic [rnad_pkg::BG_REG_W-1:0]  r_bg;
    logic [rnad_pkg::FW_REG_W-1:0]  r_fw;
    logic [rnad_pkg::FH_REG_W-1:0]  r_fh;
    logic [rnad_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr;

    rnad_pkg::t_geom geom;
    rnad_pkg::t_job  push_job;
    rnad_pkg::t_job  head_job;
    logic            q_push;
    logic            q_pop;
    logic [QW-1:0]   q_count;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg <= '0;
            r_fw <= rnad_pkg::FW_REG_W'(1);
            r_fh <= rnad_pkg::FH_REG_W'(1);
        end else if (wr) begin
            case (reg_idx)
                rnad_pkg::REG_BACKGROUND: r_bg <= pwdata[rnad_pkg::BG_REG_W-1:0];
                rnad_pkg::REG_WIDTH:      r_fw <= pwdata[rnad_pkg::FW_REG_W-1:0];
                rnad_pkg::REG_HEIGHT:     r_fh <= pwdata[rnad_pkg::FH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rnad_pkg::REG_BACKGROUND: prdata = rnad_pkg::APB_DATA_W'(r_bg);
            rnad_pkg::REG_WIDTH:      prdata = rnad_pkg::APB_DATA_W'(r_fw);
            rnad_pkg::REG_HEIGHT:     prdata = rnad_pkg::APB_DATA_W'(r_fh);
            default:                  prdata = '0;
        endcase
    end

    // geometry writes restart the position counters on the same edge
    assign geom.width   = r_fw;
    assign geom.height  = r_fh;
    assign geom.restart = wr && ((reg_idx == rnad_pkg::REG_WIDTH)
                              || (reg_idx == rnad_pkg::REG_HEIGHT));

    // front: position tracking, line stores, window
    rnad_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_geom    (geom),
        .i_q_count (q_count),
        .o_push    (q_push),
        .o_job     (push_job)
    );

    // windows waiting for the averaging pipeline
    rnad_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_job),
        .i_pop   (q_pop),
        .o_head  (head_job),
        .o_count (q_count)
    );

    // back: masked sum, reciprocal divide, output register
    rnad_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_count != '0),
        .i_head    (head_job),
        .i_bg      (r_bg),
        .o_pop     (q_pop),
        .o_pix     (o_pix)
    );

`ifndef ASSERT_OFF
    // front credit must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_count < QW'(QUEUE_DEPTH)))
        else $error("window queue overflow");

    // back only pops what is there
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_count != '0))
        else $error("window queue underflow");

    // input backpressure only comes from queued work
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (q_count != '0))
        else $error("input held off with an empty queue");
`endif

endmodule
